### design/tpco_pkg.sv
// Package for the two-plane cursor overlay: transaction structs, command,
// mode and register codes, and the cursor colour formatter.
// No dependencies.
`default_nettype none

package tpco_pkg;

  // Width of one pattern word; bit 31 is the leftmost column
  localparam int unsigned WORD_BITS = 32;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_PIXEL   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_COLOUR  = 2'd2
  } cmd_e;

  // Pixel formats
  typedef enum logic [2:0] {
    MODE_INDEX8 = 3'd0,
    MODE_RGB555 = 3'd1,
    MODE_RGB565 = 3'd2,
    MODE_RGB24  = 3'd3,
    MODE_RGB32  = 3'd4
  } mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CURSOR_LEFT    = 3'd0,
    REG_CURSOR_TOP     = 3'd1,
    REG_CURSOR_CHOICE  = 3'd2,
    REG_PIXEL_MODE     = 3'd3,
    REG_CURSOR_VISIBLE = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // Colour field masks
  localparam logic [31:0] MASK_R5   = 32'h00f8_0000;
  localparam logic [31:0] MASK_G5   = 32'h0000_f800;
  localparam logic [31:0] MASK_G6   = 32'h0000_fc00;
  localparam logic [31:0] MASK_B5   = 32'h0000_00f8;
  localparam logic [31:0] MASK_RGB  = 32'h00ff_ffff;

  // Input transaction
  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic [31:0] background;
    logic [3:0]  image_slot;
    logic [5:0]  word_slot;
    logic [31:0] pattern_bits;
    logic        colour_pick;
    logic [31:0] colour_rgb;
    logic [7:0]  colour_index;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [31:0] pixel_out;
    logic        cursor_hit;
  } out_item_t;

  // Formats a stored cursor colour for the given pixel mode
  function automatic logic [31:0] format_colour(input logic [31:0] rgb,
                                                input logic [7:0]  idx,
                                                input mode_e       mode);
    logic [31:0] px;
    case (mode)
      MODE_INDEX8: px = {24'h0, idx};
      MODE_RGB555: px = ((rgb & MASK_R5) >> 9) | ((rgb & MASK_G5) >> 5)
                        | ((rgb & MASK_B5) >> 3);
      MODE_RGB565: px = ((rgb & MASK_R5) >> 8) | ((rgb & MASK_G6) >> 5)
                        | ((rgb & MASK_B5) >> 3);
      MODE_RGB24:  px = rgb & MASK_RGB;
      MODE_RGB32:  px = rgb;
      default:     px = 32'h0;
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

### design/tpco_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tpco_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/two_plane_cursor_overlay_unit.sv
// Top level of the two-plane cursor overlay: config registers, pattern RAMs,
// colour store and the two-stage pixel pipeline.
// Depends on tpco_pkg and tpco_ram.
`default_nettype none

// Hardware cursor overlay for CURSOR_DIM x CURSOR_DIM two-plane cursors with
// NUM_IMAGES stored images. One transaction (pixel, pattern write or colour
// write) is accepted per clock while in_stall_o is low. For a pixel, the
// accepting edge reads the colour-plane and mask-plane RAMs (one RAM per
// plane, registered read); the edge that moves it on into the output register,
// taken when that register has room, picks the mask and colour bits, formats
// the cursor colour and loads the output register. Write transactions produce
// no result. in_stall_o rises only when both the RAM stage and the output
// register hold pixels and out_stall_i is high. There is no clearing pass;
// pattern and colour entries must be written before a visible cursor uses them.
module two_plane_cursor_overlay_unit #(
  parameter int unsigned NUM_IMAGES = 16,
  parameter int unsigned CURSOR_DIM = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire tpco_pkg::in_item_t                 in_item_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output tpco_pkg::out_item_t                     out_item_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tpco_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [tpco_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IMG_W   = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;
  localparam int unsigned ENT_W   = IMG_W + 1;
  localparam int unsigned ROW_W   = $clog2(CURSOR_DIM);
  localparam int unsigned DEPTH   = NUM_IMAGES * CURSOR_DIM;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NUM_ENT = 2 * NUM_IMAGES;
  localparam int unsigned SEL_W   = $clog2(tpco_pkg::WORD_BITS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [11:0] cfg_left_q;
  logic [11:0] cfg_top_q;
  logic [3:0]  cfg_choice_q;
  logic [2:0]  cfg_mode_q;
  logic        cfg_visible_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_left_q    <= '0;
      cfg_top_q     <= '0;
      cfg_choice_q  <= '0;
      cfg_mode_q    <= '0;
      cfg_visible_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (tpco_pkg::cfg_reg_e'(cfg_index_i))
        tpco_pkg::REG_CURSOR_LEFT:    cfg_left_q    <= cfg_data_i[11:0];
        tpco_pkg::REG_CURSOR_TOP:     cfg_top_q     <= cfg_data_i[11:0];
        tpco_pkg::REG_CURSOR_CHOICE:  cfg_choice_q  <= cfg_data_i[3:0];
        tpco_pkg::REG_PIXEL_MODE:     cfg_mode_q    <= cfg_data_i[2:0];
        tpco_pkg::REG_CURSOR_VISIBLE: cfg_visible_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic b_valid_q, b_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, b_ready, in_acc, pix_acc;
  tpco_pkg::cmd_e in_cmd;

  assign in_cmd     = tpco_pkg::cmd_e'(in_item_i.cmd);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_ready    = !b_valid_q || out_ready;
  assign in_stall_o = !b_ready;
  assign in_acc     = in_valid_i && b_ready;
  assign pix_acc    = in_acc && (in_cmd == tpco_pkg::CMD_PIXEL);

  always_comb begin
    b_valid_d   = b_ready ? pix_acc : b_valid_q;
    out_valid_d = out_ready ? b_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Write decode
  // ---------------------------------------------------------------------
  logic             img_ok;
  logic [7:0]       word_ext;
  logic             word_ok, word_is_mask;
  logic [ROW_W-1:0] wr_row;
  logic [ADDR_W-1:0] wr_addr;
  logic             we_colour_plane, we_mask_plane, we_colour;
  logic [ENT_W-1:0] wr_ent;

  always_comb begin
    img_ok       = 32'(in_item_i.image_slot) < NUM_IMAGES;
    word_ext     = {2'b00, in_item_i.word_slot};
    word_ok      = word_ext < 8'(2 * CURSOR_DIM);
    word_is_mask = word_ext >= 8'(CURSOR_DIM);
    wr_row       = word_is_mask ? ROW_W'(word_ext - 8'(CURSOR_DIM)) : ROW_W'(word_ext);
    wr_addr      = ADDR_W'(ADDR_W'(in_item_i.image_slot) * ADDR_W'(CURSOR_DIM)
                           + ADDR_W'(wr_row));
    wr_ent       = {IMG_W'(in_item_i.image_slot), in_item_i.colour_pick};
    we_colour_plane = 1'b0;
    we_mask_plane   = 1'b0;
    we_colour       = 1'b0;
    case (in_cmd)
      tpco_pkg::CMD_PATTERN: begin
        we_colour_plane = in_acc && img_ok && word_ok && !word_is_mask;
        we_mask_plane   = in_acc && img_ok && word_ok && word_is_mask;
      end
      tpco_pkg::CMD_COLOUR: begin
        we_colour = in_acc && img_ok;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage A: window check and pattern RAM read address
  // ---------------------------------------------------------------------
  logic [12:0]       dx, dy;
  logic              in_window, choice_ok, mode_ok, show_a;
  logic [ADDR_W-1:0] rd_addr;
  logic [IMG_W-1:0]  choice_img;

  always_comb begin
    dx         = {1'b0, in_item_i.screen_x} - {1'b0, cfg_left_q};
    dy         = {1'b0, in_item_i.screen_y} - {1'b0, cfg_top_q};
    in_window  = !dx[12] && !dy[12]
                 && (dx[11:0] < 12'(CURSOR_DIM)) && (dy[11:0] < 12'(CURSOR_DIM))
                 && (dx[11:0] < 12'(tpco_pkg::WORD_BITS));
    choice_ok  = 32'(cfg_choice_q) < NUM_IMAGES;
    mode_ok    = cfg_mode_q <= tpco_pkg::MODE_RGB32;
    show_a     = cfg_visible_q && choice_ok && mode_ok && in_window;
    choice_img = IMG_W'(cfg_choice_q);
    rd_addr    = ADDR_W'(ADDR_W'(choice_img) * ADDR_W'(CURSOR_DIM)
                         + ADDR_W'(dy[ROW_W-1:0]));
  end

  // Stage B payload registers
  logic [31:0]      b_bg_q;
  logic [SEL_W-1:0] b_sel_q;
  logic             b_show_q;

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_bg_q   <= in_item_i.background;
      b_sel_q  <= SEL_W'(tpco_pkg::WORD_BITS - 1) - dx[SEL_W-1:0];
      b_show_q <= show_a;
    end
  end

  // Pattern planes: one RAM each, read together for the same row
  logic [31:0] colour_plane_rd, mask_plane_rd;

  tpco_ram #(
    .WIDTH (tpco_pkg::WORD_BITS),
    .DEPTH (DEPTH)
  ) u_colour_plane (
    .clk_i   (clk_i),
    .we_i    (we_colour_plane),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.pattern_bits),
    .re_i    (b_ready),
    .raddr_i (rd_addr),
    .rdata_o (colour_plane_rd)
  );

  tpco_ram #(
    .WIDTH (tpco_pkg::WORD_BITS),
    .DEPTH (DEPTH)
  ) u_mask_plane (
    .clk_i   (clk_i),
    .we_i    (we_mask_plane),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.pattern_bits),
    .re_i    (b_ready),
    .raddr_i (rd_addr),
    .rdata_o (mask_plane_rd)
  );

  // Cursor colours, two per image
  logic [31:0] colour_q [NUM_ENT];
  logic [7:0]  index_q  [NUM_ENT];

  always_ff @(posedge clk_i) begin
    if (we_colour) begin
      colour_q[wr_ent] <= in_item_i.colour_rgb;
      index_q[wr_ent]  <= in_item_i.colour_index;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: pick pattern bits, format colour
  // ---------------------------------------------------------------------
  logic              cbit, mbit, hit_b;
  logic [ENT_W-1:0]  rd_ent;
  tpco_pkg::out_item_t res_b;
  tpco_pkg::out_item_t out_item_q;

  always_comb begin
    cbit   = colour_plane_rd[b_sel_q];
    mbit   = mask_plane_rd[b_sel_q];
    hit_b  = b_show_q && mbit;
    rd_ent = {choice_img, cbit};
    res_b.cursor_hit = hit_b;
    res_b.pixel_out  = hit_b
      ? tpco_pkg::format_colour(colour_q[rd_ent], index_q[rd_ent],
                                tpco_pkg::mode_e'(cfg_mode_q))
      : b_bg_q;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_ready && b_valid_q) begin
      out_item_q <= res_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pixel_enters_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> b_valid_q)
    else $error("accepted pixel did not reach the RAM stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.cmd != tpco_pkg::CMD_PIXEL)) |=> !b_valid_q)
    else $error("write transaction created a pipeline entry");

  a_b_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_ready) |=> (b_valid_q && $stable(b_bg_q) && $stable(b_sel_q)))
    else $error("RAM stage changed while blocked");

  a_b_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && out_ready) |=> out_valid_q)
    else $error("pixel lost between RAM stage and output register");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (b_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
